>>> rtl/nonfinite_value_scanner_assert.svh
// Assertion macros for the nonfinite value scanner.
`ifndef NONFINITE_VALUE_SCANNER_ASSERT_SVH
`define NONFINITE_VALUE_SCANNER_ASSERT_SVH
`ifndef ASSERT_OFF
`define NVS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NVS_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NVS_ASSERT(name, prop, msg)
`define NVS_ASSERT_NEVER(name, cond, msg)
`endif
`endif

>>> rtl/nvs_pkg.sv
`timescale 1ns / 1ps

package nvs_pkg;

    localparam int CountWidth     = 32;
    localparam int MaxSamples     = 64;
    localparam int FieldWidth     = 32;
    localparam int ElemWidth      = 64;
    localparam int FormatWidth    = 3;
    localparam int MaxRepWidth    = 7;
    localparam int CfgIndexWidth  = 2;
    localparam int CfgDataWidth   = 7;
    localparam int FifoDepth      = 3;
    localparam int FifoPtrWidth   = $clog2(FifoDepth);
    localparam int FifoCountWidth = $clog2(FifoDepth + 1);

    localparam logic [FormatWidth-1:0] FormatReset = FormatWidth'(4);
    localparam logic [MaxRepWidth-1:0] MaxRepReset = MaxRepWidth'(16);

    typedef enum logic [FormatWidth-1:0] {
        FMT_E4M3 = 3'd0,
        FMT_E5M2 = 3'd1,
        FMT_FP16 = 3'd2,
        FMT_BF16 = 3'd3,
        FMT_FP32 = 3'd4,
        FMT_FP64 = 3'd5
    } format_t;

    typedef enum logic [1:0] {
        KIND_NAN     = 2'd0,
        KIND_POS_INF = 2'd1,
        KIND_NEG_INF = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_DATA_FORMAT  = 2'd0,
        CFG_MAX_REPORTED = 2'd1
    } cfg_index_t;

    typedef enum logic {
        RES_SAMPLE  = 1'b0,
        RES_SUMMARY = 1'b1
    } result_type_t;

    typedef struct packed {
        logic                  result_type;
        logic [FieldWidth-1:0] element_index;
        logic [1:0]            sample_kind;
        logic [FieldWidth-1:0] checked_count;
        logic [FieldWidth-1:0] nonfinite_total;
        logic [FieldWidth-1:0] nan_total;
        logic [FieldWidth-1:0] pos_inf_total;
        logic [FieldWidth-1:0] neg_inf_total;
        logic                  final_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [FifoCountWidth-1:0] count;
        logic [FifoCountWidth-1:0] free;
    } fifo_status_t;

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        return (v == {CountWidth{1'b1}}) ? v : v + CountWidth'(1);
    endfunction

    function automatic logic [FieldWidth-1:0] show32(input logic [CountWidth-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? {FieldWidth{1'b1}} : w[FieldWidth-1:0];
    endfunction

endpackage

>>> rtl/nvs_if.sv
`timescale 1ns / 1ps

interface nvs_elem_if;
    logic                          valid;
    logic                          ready;
    logic [nvs_pkg::ElemWidth-1:0] element_bits;
    logic                          last_element;

    modport source (output valid, output element_bits, output last_element, input ready);
    modport sink   (input valid, input element_bits, input last_element, output ready);
endinterface

interface nvs_result_if;
    logic                           valid;
    logic                           ready;
    logic                           result_type;
    logic [nvs_pkg::FieldWidth-1:0] element_index;
    logic [1:0]                     sample_kind;
    logic [nvs_pkg::FieldWidth-1:0] checked_count;
    logic [nvs_pkg::FieldWidth-1:0] nonfinite_total;
    logic [nvs_pkg::FieldWidth-1:0] nan_total;
    logic [nvs_pkg::FieldWidth-1:0] pos_inf_total;
    logic [nvs_pkg::FieldWidth-1:0] neg_inf_total;
    logic                           final_of_run;

    modport source (output valid, output result_type, output element_index, output sample_kind,
                    output checked_count, output nonfinite_total, output nan_total,
                    output pos_inf_total, output neg_inf_total, output final_of_run,
                    input ready);
    modport sink   (input valid, input result_type, input element_index, input sample_kind,
                    input checked_count, input nonfinite_total, input nan_total,
                    input pos_inf_total, input neg_inf_total, input final_of_run,
                    output ready);
endinterface

interface nvs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nvs_pkg::CfgIndexWidth-1:0] index;
    logic [nvs_pkg::CfgDataWidth-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/nonfinite_value_scanner.sv
`timescale 1ns / 1ps
//  channel  dir  word                                        handshake
//  cfg      in   index, data (register write)                valid/ready
//  elem     in   element_bits, last_element                  valid/ready
//  result   out  sample or summary record, final_of_run      valid/ready
//
//  One element per cycle while the queue has room: each waits in the input
//  register, then classification and counter update write its results
//  into a three-entry result queue. An element marked last that also
//  yields a sample makes two words, which drain at one per cycle. Reset
//  clears all counters and sets data_format to fp32 and max_reported to
//  16. A stall on the result side fills the queue, then holds the input.
`include "nonfinite_value_scanner_assert.svh"

module nonfinite_value_scanner (
    input  logic                 clk,
    input  logic                 rst_n,
    nvs_cfg_if.sink              cfg,
    nvs_elem_if.sink             elem,
    nvs_result_if.source         result
);

    logic [nvs_pkg::FormatWidth-1:0] data_format_reg;
    logic [nvs_pkg::MaxRepWidth-1:0] max_reported_reg;
    logic                            in_valid_reg;
    logic [nvs_pkg::ElemWidth-1:0]   in_bits_reg;
    logic                            in_last_reg;
    nvs_pkg::kind_t                  kind;
    logic                            consume;
    nvs_pkg::push_t                  push;
    nvs_pkg::result_t                head;
    nvs_pkg::fifo_status_t           fifo_status;
    logic                            pop;

    assign cfg.ready  = 1'b1;
    assign elem.ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_format_reg  <= nvs_pkg::FormatReset;
            max_reported_reg <= nvs_pkg::MaxRepReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                nvs_pkg::CFG_DATA_FORMAT:
                    data_format_reg <= cfg.data[nvs_pkg::FormatWidth-1:0];
                nvs_pkg::CFG_MAX_REPORTED:
                    max_reported_reg <= cfg.data[nvs_pkg::MaxRepWidth-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (elem.ready)
            in_valid_reg <= elem.valid;
    end

    always_ff @(posedge clk)
    begin
        if (elem.ready && elem.valid)
        begin
            in_bits_reg <= elem.element_bits;
            in_last_reg <= elem.last_element;
        end
    end

    nvs_classify u_classify (
        .data_format  (data_format_reg),
        .element_bits (in_bits_reg),
        .kind         (kind)
    );

    nvs_tally u_tally (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid_reg),
        .last_element (in_last_reg),
        .kind         (kind),
        .max_reported (max_reported_reg),
        .fifo_status  (fifo_status),
        .consume      (consume),
        .push         (push)
    );

    assign pop = result.valid && result.ready;

    nvs_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (fifo_status)
    );

    assign result.valid           = (fifo_status.count != '0);
    assign result.result_type     = head.result_type;
    assign result.element_index   = head.element_index;
    assign result.sample_kind     = head.sample_kind;
    assign result.checked_count   = head.checked_count;
    assign result.nonfinite_total = head.nonfinite_total;
    assign result.nan_total       = head.nan_total;
    assign result.pos_inf_total   = head.pos_inf_total;
    assign result.neg_inf_total   = head.neg_inf_total;
    assign result.final_of_run    = head.final_of_run;

    `NVS_ASSERT_NEVER(a_queue_over, fifo_status.count > nvs_pkg::FifoCountWidth'(nvs_pkg::FifoDepth), "result queue over depth")
    `NVS_ASSERT(a_push_fits, push.count != 2'd0 |-> nvs_pkg::FifoCountWidth'(push.count) <= fifo_status.free, "push exceeds free space")
    `NVS_ASSERT(a_summary_final, result.valid && result.result_type |-> result.final_of_run, "summary not final")
    `NVS_ASSERT_NEVER(a_sample_kind, result.valid && !result.result_type && result.sample_kind == nvs_pkg::KIND_NONE, "sample without kind")

endmodule

>>> rtl/nvs_classify.sv
`timescale 1ns / 1ps

module nvs_classify (
    input  logic [nvs_pkg::FormatWidth-1:0] data_format,
    input  logic [nvs_pkg::ElemWidth-1:0]   element_bits,
    output nvs_pkg::kind_t                  kind
);

    function automatic nvs_pkg::kind_t ieee_kind(input logic exp_ones,
                                                 input logic man_zero,
                                                 input logic sign);
        if (!exp_ones)
            return nvs_pkg::KIND_NONE;
        if (!man_zero)
            return nvs_pkg::KIND_NAN;
        return sign ? nvs_pkg::KIND_NEG_INF : nvs_pkg::KIND_POS_INF;
    endfunction

    always_comb
    begin
        case (data_format)
            nvs_pkg::FMT_E4M3:
                kind = (element_bits[6:0] == 7'h7F) ? nvs_pkg::KIND_NAN : nvs_pkg::KIND_NONE;
            nvs_pkg::FMT_E5M2:
                kind = ieee_kind(&element_bits[6:2], element_bits[1:0] == '0,
                                 element_bits[7]);
            nvs_pkg::FMT_FP16:
                kind = ieee_kind(&element_bits[14:10], element_bits[9:0] == '0,
                                 element_bits[15]);
            nvs_pkg::FMT_BF16:
                kind = ieee_kind(&element_bits[14:7], element_bits[6:0] == '0,
                                 element_bits[15]);
            nvs_pkg::FMT_FP32:
                kind = ieee_kind(&element_bits[30:23], element_bits[22:0] == '0,
                                 element_bits[31]);
            nvs_pkg::FMT_FP64:
                kind = ieee_kind(&element_bits[62:52], element_bits[51:0] == '0,
                                 element_bits[63]);
            default:
                kind = nvs_pkg::KIND_NONE;
        endcase
    end

endmodule

>>> rtl/nvs_tally.sv
`timescale 1ns / 1ps

module nvs_tally (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 last_element,
    input  nvs_pkg::kind_t                       kind,
    input  logic [nvs_pkg::MaxRepWidth-1:0]      max_reported,
    input  nvs_pkg::fifo_status_t                fifo_status,
    output logic                                 consume,
    output nvs_pkg::push_t                       push
);

    logic [nvs_pkg::CountWidth-1:0] position_reg, position_next;
    logic [nvs_pkg::CountWidth-1:0] nan_cnt_reg, nan_cnt_next;
    logic [nvs_pkg::CountWidth-1:0] pos_cnt_reg, pos_cnt_next;
    logic [nvs_pkg::CountWidth-1:0] neg_cnt_reg, neg_cnt_next;
    logic [nvs_pkg::CountWidth-1:0] nonfin_cnt_reg, nonfin_cnt_next;
    logic [nvs_pkg::MaxRepWidth-1:0] limit;
    logic                           nonfinite;
    logic                           sample;
    logic [1:0]                     need;
    nvs_pkg::result_t               sample_res;
    nvs_pkg::result_t               summary_res;

    always_comb
    begin
        limit = (max_reported > nvs_pkg::MaxRepWidth'(nvs_pkg::MaxSamples))
              ? nvs_pkg::MaxRepWidth'(nvs_pkg::MaxSamples) : max_reported;
        nonfinite = (kind != nvs_pkg::KIND_NONE);
        sample    = nonfinite && (nonfin_cnt_reg < nvs_pkg::CountWidth'(limit));
        need      = {1'b0, sample} + {1'b0, last_element};
        consume   = in_valid && (fifo_status.free >= nvs_pkg::FifoCountWidth'(need));

        position_next   = nvs_pkg::sat_inc(position_reg);
        nan_cnt_next    = (kind == nvs_pkg::KIND_NAN) ? nvs_pkg::sat_inc(nan_cnt_reg)
                                                      : nan_cnt_reg;
        pos_cnt_next    = (kind == nvs_pkg::KIND_POS_INF) ? nvs_pkg::sat_inc(pos_cnt_reg)
                                                          : pos_cnt_reg;
        neg_cnt_next    = (kind == nvs_pkg::KIND_NEG_INF) ? nvs_pkg::sat_inc(neg_cnt_reg)
                                                          : neg_cnt_reg;
        nonfin_cnt_next = nonfinite ? nvs_pkg::sat_inc(nonfin_cnt_reg) : nonfin_cnt_reg;

        sample_res               = '0;
        sample_res.result_type   = nvs_pkg::RES_SAMPLE;
        sample_res.element_index = nvs_pkg::show32(position_reg);
        sample_res.sample_kind   = kind;
        sample_res.final_of_run  = !last_element;

        summary_res                 = '0;
        summary_res.result_type     = nvs_pkg::RES_SUMMARY;
        summary_res.checked_count   = nvs_pkg::show32(position_next);
        summary_res.nonfinite_total = nvs_pkg::show32(nonfin_cnt_next);
        summary_res.nan_total       = nvs_pkg::show32(nan_cnt_next);
        summary_res.pos_inf_total   = nvs_pkg::show32(pos_cnt_next);
        summary_res.neg_inf_total   = nvs_pkg::show32(neg_cnt_next);
        summary_res.final_of_run    = 1'b1;

        push.count  = consume ? need : 2'd0;
        push.first  = sample ? sample_res : summary_res;
        push.second = summary_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            nan_cnt_reg    <= '0;
            pos_cnt_reg    <= '0;
            neg_cnt_reg    <= '0;
            nonfin_cnt_reg <= '0;
        end
        else if (consume)
        begin
            if (last_element)
            begin
                position_reg   <= '0;
                nan_cnt_reg    <= '0;
                pos_cnt_reg    <= '0;
                neg_cnt_reg    <= '0;
                nonfin_cnt_reg <= '0;
            end
            else
            begin
                position_reg   <= position_next;
                nan_cnt_reg    <= nan_cnt_next;
                pos_cnt_reg    <= pos_cnt_next;
                neg_cnt_reg    <= neg_cnt_next;
                nonfin_cnt_reg <= nonfin_cnt_next;
            end
        end
    end

endmodule

>>> rtl/nvs_result_fifo.sv
`timescale 1ns / 1ps

module nvs_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nvs_pkg::push_t        push,
    input  logic                  pop,
    output nvs_pkg::result_t      head,
    output nvs_pkg::fifo_status_t status
);

    nvs_pkg::result_t                   entry_reg [nvs_pkg::FifoDepth];
    logic [nvs_pkg::FifoPtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [nvs_pkg::FifoPtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [nvs_pkg::FifoCountWidth-1:0] count_reg, count_next;
    logic [nvs_pkg::FifoPtrWidth-1:0]   wr_ptr_1;

    function automatic logic [nvs_pkg::FifoPtrWidth-1:0] ptr_inc(
        input logic [nvs_pkg::FifoPtrWidth-1:0] p);
        return (p == nvs_pkg::FifoPtrWidth'(nvs_pkg::FifoDepth - 1))
             ? '0 : p + nvs_pkg::FifoPtrWidth'(1);
    endfunction

    always_comb
    begin
        wr_ptr_1 = ptr_inc(wr_ptr_reg);
        case (push.count)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + nvs_pkg::FifoCountWidth'(push.count)
                    - nvs_pkg::FifoCountWidth'(pop);
        head         = entry_reg[rd_ptr_reg];
        status.count = count_reg;
        status.free  = nvs_pkg::FifoCountWidth'(nvs_pkg::FifoDepth) - count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < nvs_pkg::FifoDepth; i++)
        begin
            if (push.count != 2'd0 && nvs_pkg::FifoPtrWidth'(i) == wr_ptr_reg)
                entry_reg[i] <= push.first;
            else if (push.count == 2'd2 && nvs_pkg::FifoPtrWidth'(i) == wr_ptr_1)
                entry_reg[i] <= push.second;
        end
    end

endmodule
